>>> rtl/rte_pkg.sv
// Shared types and constants for the routing table engine.
// Used by every module under rtl; depends on nothing.
`default_nettype none

package rte_pkg;

    typedef enum logic [2:0] {
        OP_HELLO  = 3'd0,
        OP_ADD    = 3'd1,
        OP_UPDATE = 3'd2,
        OP_REMOVE = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WALK = 2'd1,
        S_FIN  = 2'd2
    } t_state;

    localparam logic [6:0] BATCH_MAX = 7'd127;
    localparam logic [7:0] HELLO_COST = 8'd1;

    typedef struct packed {
        logic [15:0] dest;
        logic [7:0]  cost;
        logic [15:0] hop;
    } t_entry;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  index;
        logic [15:0] dest;
        logic [7:0]  cost;
        logic [15:0] hop;
        logic        batch_last;
    } t_req;

    typedef struct packed {
        logic [15:0] out_dest;
        logic [7:0]  out_cost;
        logic [15:0] out_hop;
        logic [6:0]  entry_count;
        logic        matched;
        t_status     status;
    } t_rsp;

endpackage

`default_nettype wire

>>> rtl/rte_cell.sv
// One table slot of the rotating route ring.
// Takes its neighbour's entry on every shift cycle. Depends on rte_pkg.
`default_nettype none

module rte_cell
    import rte_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = i_shift ? i_entry : r_entry;
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> rtl/rte_ctrl.sv
// Sequencer for the route ring: request decode, one full rotation per
// request that passes the up-front checks, head-of-ring edits and the result register. Depends on rte_pkg.
`default_nettype none

module rte_ctrl
    import rte_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_in_valid,
    output logic   o_in_ready,
    input  t_req   i_in_data,
    output logic   o_out_valid,
    input  wire    i_out_ready,
    output t_rsp   o_out_data,
    input  t_entry i_head,
    input  t_entry i_next,
    output logic   o_shift,
    output t_entry o_feed
);

    localparam int PW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    logic [CW-1:0]    r_count, n_count;
    logic [6:0]       r_batch, n_batch;
    logic [PW-1:0]    r_pos, n_pos;
    logic [PW-1:0]    r_tgt, n_tgt;
    logic             r_found, n_found;
    t_entry           r_cap, n_cap;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic             accept;
    logic [CMPW-1:0]  idx_ext, cnt_ext, br_ext, rm_pos;
    logic [CW-1:0]    pos_cnt;
    logic             head_live, at_count, at_tgt, last_step, out_free;
    t_entry           new_entry;
    t_rsp             imm_rsp, walk_rsp;
    logic [CW-1:0]    walk_count;

    always_comb begin
        idx_ext   = CMPW'(i_in_data.index);
        cnt_ext   = CMPW'(r_count);
        br_ext    = CMPW'(r_batch);
        rm_pos    = idx_ext - br_ext;
        pos_cnt   = CW'(r_pos);
        head_live = pos_cnt < r_count;
        at_count  = pos_cnt == r_count;
        at_tgt    = r_pos == r_tgt;
        last_step = r_pos == PW'(TABLE_DEPTH - 1);
        out_free  = !r_out_valid || i_out_ready;
        new_entry = '{dest: r_req.dest, cost: r_req.cost, hop: r_req.hop};
    end

    // result of a request that finished its rotation
    always_comb begin
        walk_rsp             = '0;
        walk_rsp.status      = ST_OK;
        walk_count           = r_count;
        unique case (t_op'(r_req.op))
            OP_HELLO: begin
                if (r_found) begin
                    walk_rsp.out_dest = r_req.dest;
                    walk_rsp.out_cost = HELLO_COST;
                    walk_rsp.out_hop  = r_cap.hop;
                    walk_rsp.matched  = 1'b1;
                end else if (r_count == CW'(TABLE_DEPTH)) begin
                    walk_rsp.status = ST_FULL;
                end else begin
                    walk_rsp.out_dest = r_req.dest;
                    walk_rsp.out_cost = HELLO_COST;
                    walk_rsp.out_hop  = r_req.dest;
                    walk_count        = r_count + CW'(1);
                end
            end
            OP_ADD: begin
                walk_rsp.out_dest = r_req.dest;
                walk_rsp.out_cost = r_req.cost;
                walk_rsp.out_hop  = r_req.hop;
                walk_count        = r_count + CW'(1);
            end
            OP_UPDATE: begin
                walk_rsp.out_dest = r_req.dest;
                walk_rsp.out_cost = r_req.cost;
                walk_rsp.out_hop  = r_req.hop;
            end
            OP_REMOVE: begin
                walk_rsp.out_dest = r_cap.dest;
                walk_rsp.out_cost = r_cap.cost;
                walk_rsp.out_hop  = r_cap.hop;
                walk_count        = r_count - CW'(1);
            end
            OP_READ: begin
                walk_rsp.out_dest = r_cap.dest;
                walk_rsp.out_cost = r_cap.cost;
                walk_rsp.out_hop  = r_cap.hop;
            end
            default: begin
            end
        endcase
        walk_rsp.entry_count = 7'(walk_count);
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_batch     = r_batch;
        n_pos       = r_pos;
        n_tgt       = r_tgt;
        n_found     = r_found;
        n_cap       = r_cap;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        o_shift     = 1'b0;
        o_feed      = i_head;
        accept      = 1'b0;

        imm_rsp             = '0;
        imm_rsp.status      = ST_OK;
        imm_rsp.entry_count = 7'(r_count);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = out_free;
                accept     = i_in_valid && out_free;
                if (accept) begin
                    n_req   = i_in_data;
                    n_pos   = '0;
                    n_found = 1'b0;
                    n_cap   = '0;
                    n_state = S_WALK;
                    unique case (t_op'(i_in_data.op)) inside
                        OP_HELLO: begin
                        end
                        OP_ADD: begin
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                imm_rsp.status = ST_FULL;
                                n_state        = S_IDLE;
                            end
                        end
                        OP_UPDATE, OP_READ: begin
                            if (idx_ext >= cnt_ext) begin
                                imm_rsp.status = ST_RANGE;
                                n_state        = S_IDLE;
                            end else begin
                                n_tgt = PW'(idx_ext);
                            end
                        end
                        OP_REMOVE: begin
                            if (idx_ext < br_ext || rm_pos >= cnt_ext) begin
                                imm_rsp.status = ST_RANGE;
                                n_state        = S_IDLE;
                            end else begin
                                n_tgt   = PW'(rm_pos);
                                n_batch = (r_batch == BATCH_MAX) ? r_batch
                                                                 : r_batch + 7'd1;
                            end
                            if (i_in_data.batch_last) begin
                                n_batch = '0;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                    if (n_state == S_IDLE) begin
                        n_out_valid = 1'b1;
                        n_out       = imm_rsp;
                    end
                end
            end
            S_WALK: begin
                o_shift = 1'b1;
                n_pos   = r_pos + PW'(1);
                unique case (t_op'(r_req.op))
                    OP_HELLO: begin
                        if (head_live && i_head.dest == r_req.dest) begin
                            o_feed.cost = HELLO_COST;
                            n_found     = 1'b1;
                            if (!r_found) begin
                                n_cap.hop = i_head.hop;
                            end
                        end
                        // all live slots have passed by now, so the match flag is final
                        if (at_count && !r_found) begin
                            o_feed = '{dest: r_req.dest, cost: HELLO_COST, hop: r_req.dest};
                        end
                    end
                    OP_ADD: begin
                        if (at_count) begin
                            o_feed = new_entry;
                        end
                    end
                    OP_UPDATE: begin
                        if (at_tgt) begin
                            o_feed = new_entry;
                        end
                    end
                    OP_REMOVE: begin
                        if (at_tgt) begin
                            n_cap = i_head;
                        end
                        // from the removed slot on, recirculate the following entry
                        if (r_pos >= r_tgt) begin
                            o_feed = i_next;
                        end
                    end
                    OP_READ: begin
                        if (at_tgt) begin
                            n_cap = i_head;
                        end
                    end
                    default: begin
                    end
                endcase
                if (last_step) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = walk_rsp;
                    n_count     = walk_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_batch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_batch     <= n_batch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_pos   <= n_pos;
        r_tgt   <= n_tgt;
        r_found <= n_found;
        r_cap   <= n_cap;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> rtl/routing_table_engine.sv
// Routing table engine: packed distance-vector route table held in a ring
// of rte_cell slots, sequenced by rte_ctrl. Depends on rte_pkg.
//
// Usage:
//   Requests enter on i_in_valid / o_in_ready / i_in_data (t_req) and each
//   yields exactly one result on o_out_valid / i_out_ready / o_out_data.
//   Hello, add, update, remove and read rotate the whole ring once, one slot
//   per cycle past the head, and the result is registered once the rotation
//   ends and the result register is free. A rotation passes every slot of the
//   ring, whose depth is fixed by TABLE_DEPTH.
//   Requests rejected up front (full table on add, bad index, unused op) give
//   their result in the cycle after acceptance.
//   One request is in flight at a time; the next one is taken as soon as the
//   engine is idle and the result register is empty or being drained.
//   A stalled receiver holds the result steady; a finished rotation then waits
//   until the result register frees up.
//   Reset empties the table (entry count and batch tally to zero); slot
//   contents are not cleared, as only slots below the entry count are used.
`default_nettype none

module routing_table_engine
    import rte_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  wire  i_out_ready,
    output t_rsp o_out_data
);

    t_entry cell_q [TABLE_DEPTH];
    t_entry feed;
    logic   shift;

    rte_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_head      (cell_q[0]),
        .i_next      (cell_q[1]),
        .o_shift     (shift),
        .o_feed      (feed)
    );

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        if (k == TABLE_DEPTH - 1) begin : g_tail
            rte_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_entry (feed),
                .o_entry (cell_q[k])
            );
        end else begin : g_body
            rte_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_entry (cell_q[k+1]),
                .o_entry (cell_q[k])
            );
        end
    end

endmodule

`default_nettype wire

>>> rtl/rte_checker.sv
// Port-level checks for routing_table_engine, bound to the top level.
// Depends on rte_pkg.
`default_nettype none

module rte_checker
    import rte_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  i_in_valid,
    input wire  o_in_ready,
    input t_req i_in_data,
    input wire  o_out_valid,
    input wire  i_out_ready,
    input t_rsp o_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("request dropped or changed while waiting");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.out_dest == '0 && o_out_data.out_cost == '0
            && o_out_data.out_hop == '0 && !o_out_data.matched)
        else $error("failed request returned entry data");

    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.matched |->
            o_out_data.status == ST_OK && o_out_data.out_cost == HELLO_COST)
        else $error("hello match with wrong cost or status");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> TABLE_DEPTH > 127
                        || 32'(o_out_data.entry_count) <= 32'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

endmodule

bind routing_table_engine rte_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_rte_checker (.*);

`default_nettype wire

>>> verif/tb_routing_table_engine.sv
// Self-checking testbench for routing_table_engine: random and directed route
// requests checked against a behavioural route table held in a scoreboard class.
// Depends on rtl/rte_pkg.sv and rtl/routing_table_engine.sv.
`default_nettype none

module tb_routing_table_engine;
    import rte_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_PER_PHASE = 400;
    localparam int OP_TOP = 7;          // highest 3-bit opcode

    class route_scoreboard;
        logic [15:0] dest_tab[TABLE_DEPTH];
        logic [7:0]  cost_tab[TABLE_DEPTH];
        logic [15:0] hop_tab[TABLE_DEPTH];
        int unsigned n_routes;
        int unsigned batch_done;
        t_rsp        expected_q[$];
        int unsigned n_errors;

        function new();
            n_routes = 0;
            batch_done = 0;
            n_errors = 0;
        endfunction

        function void put_route(int unsigned pos, logic [15:0] d, logic [7:0] c,
                                logic [15:0] h);
            dest_tab[pos] = d;
            cost_tab[pos] = c;
            hop_tab[pos] = h;
        endfunction

        // Applies one accepted request to the table and queues its result.
        function void note_request(t_req r);
            t_rsp        e;
            bit          found;
            int unsigned pos;
            e = '0;
            e.status = ST_OK;
            found = 0;
            case (r.op)
                OP_HELLO: begin
                    for (int i = 0; i < n_routes; i++) begin
                        if (dest_tab[i] == r.dest) begin
                            cost_tab[i] = HELLO_COST;
                            if (!found) e.out_hop = hop_tab[i];
                            found = 1;
                        end
                    end
                    if (found) begin
                        e.matched = 1'b1;
                        e.out_dest = r.dest;
                        e.out_cost = HELLO_COST;
                    end else if (n_routes >= TABLE_DEPTH) begin
                        e.status = ST_FULL;
                    end else begin
                        put_route(n_routes, r.dest, HELLO_COST, r.dest);
                        n_routes++;
                        e.out_dest = r.dest;
                        e.out_cost = HELLO_COST;
                        e.out_hop = r.dest;
                    end
                end
                OP_ADD: begin
                    if (n_routes >= TABLE_DEPTH) begin
                        e.status = ST_FULL;
                    end else begin
                        put_route(n_routes, r.dest, r.cost, r.hop);
                        n_routes++;
                        e.out_dest = r.dest;
                        e.out_cost = r.cost;
                        e.out_hop = r.hop;
                    end
                end
                OP_UPDATE: begin
                    if (r.index >= n_routes) begin
                        e.status = ST_RANGE;
                    end else begin
                        put_route(r.index, r.dest, r.cost, r.hop);
                        e.out_dest = r.dest;
                        e.out_cost = r.cost;
                        e.out_hop = r.hop;
                    end
                end
                OP_REMOVE: begin
                    // index is a pre-batch position; shift by removals so far
                    if (r.index < batch_done) begin
                        e.status = ST_RANGE;
                    end else begin
                        pos = r.index - batch_done;
                        if (pos >= n_routes) begin
                            e.status = ST_RANGE;
                        end else begin
                            e.out_dest = dest_tab[pos];
                            e.out_cost = cost_tab[pos];
                            e.out_hop = hop_tab[pos];
                            for (int i = pos; i + 1 < n_routes; i++)
                                put_route(i, dest_tab[i+1], cost_tab[i+1], hop_tab[i+1]);
                            n_routes--;
                            if (batch_done < BATCH_MAX) batch_done++;
                        end
                    end
                    if (r.batch_last) batch_done = 0;
                end
                OP_READ: begin
                    if (r.index >= n_routes) begin
                        e.status = ST_RANGE;
                    end else begin
                        e.out_dest = dest_tab[r.index];
                        e.out_cost = cost_tab[r.index];
                        e.out_hop = hop_tab[r.index];
                    end
                end
                default: ;
            endcase
            e.entry_count = 7'(n_routes);
            expected_q.push_back(e);
        endfunction

        function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                n_errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name,
                         want, got);
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp e;
            if (expected_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                return;
            end
            e = expected_q.pop_front();
            cmp_field("out_dest", e.out_dest, got.out_dest);
            cmp_field("out_cost", 16'(e.out_cost), 16'(got.out_cost));
            cmp_field("out_hop", e.out_hop, got.out_hop);
            cmp_field("entry_count", 16'(e.entry_count), 16'(got.entry_count));
            cmp_field("matched", 16'(e.matched), 16'(got.matched));
            cmp_field("status", 16'(e.status), 16'(got.status));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_data;

    route_scoreboard sb;
    t_req            batch_plan[$];
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    bit              hold_req = 0;
    bit              growing = 1;
    int unsigned     quiet = 0;

    routing_table_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_req mk_req(logic [2:0] op, logic [5:0] index, logic [15:0] d,
                                    logic [7:0] c, logic [15:0] h, logic last);
        t_req r;
        r.op = op;
        r.index = index;
        r.dest = d;
        r.cost = c;
        r.hop = h;
        r.batch_last = last;
        return r;
    endfunction

    // Random request, biased towards filling or draining the table and towards
    // well-formed ascending removal batches.
    function automatic t_req next_request();
        t_req        r, b, tmp;
        int unsigned n, pick, k, base;
        n = sb.n_routes;
        r = mk_req(OP_READ, 6'($urandom_range(63)), 16'($urandom), 8'($urandom),
                   16'($urandom), 1'($urandom_range(1)));
        if (n >= TABLE_DEPTH && $urandom_range(7) == 0) growing = 0;
        if (n <= 2) growing = 1;

        if (batch_plan.size() > 0) begin
            if ($urandom_range(9) != 0) return batch_plan.pop_front();
            // some other request in the middle of a batch
            pick = $urandom_range(2);
            r.op = (pick == 0) ? OP_READ : (pick == 1) ? OP_UPDATE : OP_ADD;
            if (n > 0) r.index = 6'($urandom_range(n - 1));
            return r;
        end

        pick = $urandom_range(99);
        if (pick < 4) begin
            r.op = 3'($urandom_range(OP_TOP, int'(OP_READ) + 1));
            return r;
        end
        pick = $urandom_range(99);
        if (growing) begin
            r.op = (pick < 40) ? OP_ADD : (pick < 65) ? OP_HELLO :
                   (pick < 75) ? OP_UPDATE : (pick < 90) ? OP_READ : OP_REMOVE;
        end else begin
            r.op = (pick < 5) ? OP_ADD : (pick < 15) ? OP_HELLO :
                   (pick < 25) ? OP_UPDATE : (pick < 40) ? OP_READ : OP_REMOVE;
        end

        if (r.op == OP_HELLO && n > 0 && $urandom_range(1) == 0)
            r.dest = sb.dest_tab[$urandom_range(n - 1)];
        if ((r.op == OP_UPDATE || r.op == OP_READ) && n > 0 && $urandom_range(99) < 85)
            r.index = 6'($urandom_range(n - 1));

        if (r.op == OP_REMOVE) begin
            k = $urandom_range(1, 4);
            base = (n > 0) ? $urandom_range(n - 1) : $urandom_range(63);
            for (int j = 0; j < k; j++) begin
                b = r;
                b.index = 6'(base);
                b.batch_last = (j == k - 1);
                b.dest = 16'($urandom);
                batch_plan.push_back(b);
                base += $urandom_range(1, 3);
            end
            // occasionally break the ascending order
            if (k > 1 && $urandom_range(9) == 0) begin
                tmp = batch_plan[0];
                batch_plan[0].index = batch_plan[1].index;
                batch_plan[1].index = tmp.index;
            end
            return batch_plan.pop_front();
        end
        return r;
    endfunction

    task automatic send(input t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(r);
    endtask

    // Result side: check, then pick next ready; long hold-off when requested.
    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("tb_routing_table_engine: errors");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 22;
        recv_idle_pct = 50;

        // empty table: every indexed op is out of range
        send(mk_req(OP_READ, 6'd0, 16'h0000, 8'h00, 16'h0000, 1'b0));
        send(mk_req(OP_UPDATE, 6'd0, 16'h1111, 8'h11, 16'h1111, 1'b0));
        send(mk_req(OP_REMOVE, 6'd0, 16'h0000, 8'h00, 16'h0000, 1'b1));
        // hello appends, then matches
        send(mk_req(OP_HELLO, 6'd0, 16'h1234, 8'h00, 16'h0000, 1'b0));
        send(mk_req(OP_HELLO, 6'd0, 16'h1234, 8'hFF, 16'hFFFF, 1'b1));
        send(mk_req(OP_ADD, 6'd63, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1));
        send(mk_req(OP_ADD, 6'd0, 16'h0000, 8'h00, 16'h0000, 1'b0));
        send(mk_req(OP_ADD, 6'd0, 16'h1234, 8'h09, 16'hBEEF, 1'b0));
        // two matching entries: hop comes from the lowest one
        send(mk_req(OP_HELLO, 6'd0, 16'h1234, 8'h00, 16'h0000, 1'b0));
        send(mk_req(OP_UPDATE, 6'd3, 16'hA5A5, 8'h80, 16'h5A5A, 1'b0));
        send(mk_req(OP_UPDATE, 6'd63, 16'h5A5A, 8'h7F, 16'hA5A5, 1'b0));
        send(mk_req(OP_READ, 6'd1, 16'h0000, 8'h00, 16'h0000, 1'b0));
        send(mk_req(OP_READ, 6'd3, 16'h0000, 8'h00, 16'h0000, 1'b0));
        send(mk_req(OP_READ, 6'd4, 16'h0000, 8'h00, 16'h0000, 1'b0));
        for (int op = int'(OP_READ) + 1; op <= OP_TOP; op++)
            send(mk_req(3'(op), 6'd2, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1));
        // batch of original positions 1 and 2
        send(mk_req(OP_REMOVE, 6'd1, 16'h0000, 8'h00, 16'h0000, 1'b0));
        send(mk_req(OP_REMOVE, 6'd2, 16'h0000, 8'h00, 16'h0000, 1'b1));
        // batch with an index below the removals so far and a read inside it
        send(mk_req(OP_REMOVE, 6'd0, 16'h0000, 8'h00, 16'h0000, 1'b0));
        send(mk_req(OP_REMOVE, 6'd0, 16'h0000, 8'h00, 16'h0000, 1'b0));
        send(mk_req(OP_READ, 6'd0, 16'h0000, 8'h00, 16'h0000, 1'b0));
        send(mk_req(OP_REMOVE, 6'd63, 16'h0000, 8'h00, 16'h0000, 1'b1));
        send(mk_req(OP_ADD, 6'd0, 16'h00FF, 8'h42, 16'hFF00, 1'b0));
        send(mk_req(OP_READ, 6'd0, 16'h0000, 8'h00, 16'h0000, 1'b0));

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 50 : 0;
            recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 22 : 0;
            if (phase == 2) hold_req = 1;
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send(next_request());
        end
        i_in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (2 * TABLE_DEPTH + 8) @(posedge i_clk);

        if (sb.n_errors == 0 && sb.expected_q.size() == 0)
            $display("tb_routing_table_engine: clean");
        else
            $display("tb_routing_table_engine: errors");
        $finish;
    end

endmodule

`default_nettype wire

>>> routing_table_engine.f
rtl/rte_pkg.sv
rtl/rte_cell.sv
rtl/rte_ctrl.sv
rtl/routing_table_engine.sv
rtl/rte_checker.sv
verif/tb_routing_table_engine.sv
